[rtl/core/sscw_pkg.sv]
// ----------------------------------------------------------------------------
// sscw_pkg
// Shared constants, types and the sine table builder for the separable
// truncated-sinc weight core.
// ----------------------------------------------------------------------------
`default_nettype none

package sscw_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int Q_BITS          = 30;
    localparam int OUT_FRAC        = 16;

    localparam int COORD_W = 32;
    localparam int D_W     = COORD_W + 1;
    localparam int EXT_W   = 23;
    localparam int U_W     = EXT_W;
    localparam int W_W     = 18;
    localparam int MAG_W   = Q_BITS + 1;
    localparam int PI_W    = 32;
    localparam int DP_W    = PI_W + U_W;
    localparam int DEN_W   = DP_W - FRAC_BITS;
    localparam int PH_W    = FRAC_BITS + SINE_TABLE_BITS + 1;
    localparam int ROM_AW  = SINE_TABLE_BITS + 1;
    localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
    localparam int DIV_STEPS = Q_BITS;
    localparam int AX_LAT  = 5 + DIV_STEPS + 1;
    localparam int Z_LAT   = 4;
    localparam int O_W     = MAG_W - (Q_BITS - OUT_FRAC);
    localparam int OUT_MAX = 65536;
    localparam int CFG_AW  = 2;

    localparam logic [MAG_W-1:0] ONE_Q    = MAG_W'(1) << Q_BITS;
    localparam logic [PI_W-1:0]  PI_Q     = 32'd3373259426;
    localparam longint unsigned  HALFPI_Q = 64'd1686629713;
    localparam logic [EXT_W-1:0] EXT_RESET = 23'd196608;

    typedef enum logic [CFG_AW-1:0] {
        CFG_EXT_X,
        CFG_EXT_Y,
        CFG_EXT_Z
    } t_cfg_idx;

    typedef struct packed {
        logic sat;
        logic neg;
    } t_div_side;

    typedef struct packed {
        logic             ok;
        logic [MAG_W-1:0] fz;
    } t_zside;

    // sin(k * pi/2 / 2^T) in Q30, odd Taylor series to x^13
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        kk   = 64'(k);
        x    = (kk * HALFPI_Q) >> SINE_TABLE_BITS;
        x2   = (x * x) >> Q_BITS;
        term = x;
        sum  = x;
        term = ((term * x2) >> Q_BITS) / 6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> Q_BITS) / 20;
        sum  = sum + term;
        term = ((term * x2) >> Q_BITS) / 42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> Q_BITS) / 72;
        sum  = sum + term;
        term = ((term * x2) >> Q_BITS) / 110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> Q_BITS) / 156;
        sum  = sum + term;
        if (sum > 64'(ONE_Q)) begin
            sum = 64'(ONE_Q);
        end
        return sum[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/sscw_sine_rom.sv]
// ----------------------------------------------------------------------------
// sscw_sine_rom
// Quarter-wave sine table, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sscw_sine_rom import sscw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ROM_AW-1:0] i_addr0,
    input  logic [ROM_AW-1:0] i_addr1,
    output logic [MAG_W-1:0]  o_data0,
    output logic [MAG_W-1:0]  o_data1
);

    logic [MAG_W-1:0] w_tbl [ROM_DEPTH];
    logic [MAG_W-1:0] r_data0;
    logic [MAG_W-1:0] r_data1;

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_tbl
        assign w_tbl[g] = sine_entry(g);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data0 <= w_tbl[i_addr0];
            r_data1 <= w_tbl[i_addr1];
        end
    end

    assign o_data0 = r_data0;
    assign o_data1 = r_data1;

endmodule

`default_nettype wire

[rtl/core/sscw_div.sv]
// ----------------------------------------------------------------------------
// sscw_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sscw_div import sscw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [DEN_W-1:0]  i_den,
    input  t_div_side         i_side,
    output logic [Q_BITS-1:0] o_quo,
    output t_div_side         o_side
);

    logic [DEN_W-1:0]  r_rem  [DIV_STEPS];
    logic [DEN_W-1:0]  r_den  [DIV_STEPS];
    logic [Q_BITS-1:0] r_quo  [DIV_STEPS];
    t_div_side         r_side [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [DEN_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [Q_BITS-1:0] w_quo;
        t_div_side         w_side;
        logic [DEN_W:0]    w_shl;
        logic              w_bit;

        if (g == 0) begin : g_first
            assign w_rem  = i_rem;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_quo  = r_quo[g-1];
            assign w_side = r_side[g-1];
        end

        assign w_shl = {w_rem, 1'b0};
        assign w_bit = (w_shl >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_bit ? DEN_W'(w_shl - {1'b0, w_den}) : w_shl[DEN_W-1:0];
                r_den[g]  <= w_den;
                r_quo[g]  <= {w_quo[Q_BITS-2:0], w_bit};
                r_side[g] <= w_side;
            end
        end
    end

    assign o_quo  = r_quo[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule

`default_nettype wire

[rtl/core/sscw_axis.sv]
// ----------------------------------------------------------------------------
// sscw_axis
// sinc magnitude and sign of one axis: phase fold, table interpolation,
// denominator product and pipelined division.
// ----------------------------------------------------------------------------
`default_nettype none

module sscw_axis import sscw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [U_W-1:0]   i_u,
    output logic [MAG_W-1:0] o_mag,
    output logic             o_neg
);

    localparam logic [PH_W-1:0] QUARTER = PH_W'(1) << (SINE_TABLE_BITS + FRAC_BITS);
    localparam int PR_W = MAG_W + FRAC_BITS;

    logic [PH_W-1:0] w_p;
    logic [PH_W-1:0] w_pm;

    // stage 1
    logic                 r1_neg;
    logic                 r1_zero;
    logic [ROM_AW-1:0]    r1_k;
    logic [FRAC_BITS-1:0] r1_r;
    logic [DP_W-1:0]      r1_denp;
    // stage 2
    logic [MAG_W-1:0]     w_t0;
    logic [MAG_W-1:0]     w_t1;
    logic [ROM_AW-1:0]    w_addr1;
    logic [DEN_W-1:0]     r2_den;
    logic [FRAC_BITS-1:0] r2_r;
    logic                 r2_full;
    logic                 r2_zero;
    logic                 r2_neg;
    // stage 3
    logic [MAG_W-1:0]     w_diff;
    logic [PR_W-1:0]      r3_prod;
    logic [MAG_W-1:0]     r3_t0;
    logic [DEN_W-1:0]     r3_den;
    logic                 r3_full;
    logic                 r3_zero;
    logic                 r3_neg;
    // stage 4
    logic [MAG_W-1:0]     r4_s;
    logic [DEN_W-1:0]     r4_den;
    logic                 r4_sat;
    logic                 r4_neg;
    // stage 5
    logic [DEN_W-1:0]     r5_rem;
    logic [DEN_W-1:0]     r5_den;
    t_div_side            r5_side;
    // divider out
    logic [Q_BITS-1:0]    w_quo;
    t_div_side            w_side;
    logic [MAG_W-1:0]     r6_mag;
    logic                 r6_neg;

    // fold the half period onto the quarter-wave table
    assign w_p  = {i_u[FRAC_BITS-1:0], (SINE_TABLE_BITS + 1)'(0)};
    assign w_pm = (w_p > QUARTER) ? PH_W'(0) - w_p : w_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg  <= i_u[FRAC_BITS];
            r1_zero <= (i_u == '0);
            r1_k    <= w_pm[PH_W-1:FRAC_BITS];
            r1_r    <= w_pm[FRAC_BITS-1:0];
            r1_denp <= DP_W'(PI_Q) * DP_W'(i_u);
        end
    end

    assign w_addr1 = r1_k[SINE_TABLE_BITS] ? r1_k : r1_k + ROM_AW'(1);

    sscw_sine_rom u_rom (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_addr0 (r1_k),
        .i_addr1 (w_addr1),
        .o_data0 (w_t0),
        .o_data1 (w_t1)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_den  <= r1_denp[DP_W-1:FRAC_BITS];
            r2_r    <= r1_r;
            r2_full <= r1_k[SINE_TABLE_BITS];
            r2_zero <= r1_zero;
            r2_neg  <= r1_neg;
        end
    end

    assign w_diff = (w_t1 > w_t0) ? w_t1 - w_t0 : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_prod <= PR_W'(w_diff) * PR_W'(r2_r);
            r3_t0   <= w_t0;
            r3_den  <= r2_den;
            r3_full <= r2_full;
            r3_zero <= r2_zero;
            r3_neg  <= r2_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_s   <= r3_full ? r3_t0 : r3_t0 + r3_prod[PR_W-1:FRAC_BITS];
            r4_den <= r3_den;
            r4_sat <= r3_zero || (r3_den == '0);
            r4_neg <= r3_neg;
        end
    end

    // quotient would reach one or more: clamp, skip the division result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_rem      <= DEN_W'(r4_s);
            r5_den      <= r4_den;
            r5_side.sat <= r4_sat || (DEN_W'(r4_s) >= r4_den);
            r5_side.neg <= r4_neg;
        end
    end

    sscw_div u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem  (r5_rem),
        .i_den  (r5_den),
        .i_side (r5_side),
        .o_quo  (w_quo),
        .o_side (w_side)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_mag <= w_side.sat ? ONE_Q : {1'b0, w_quo};
            r6_neg <= w_side.neg;
        end
    end

    assign o_mag = r6_mag;
    assign o_neg = r6_neg;

endmodule

`default_nettype wire

[rtl/core/separable_sinc_quartic_weight_core.sv]
// Throughput: one item per cycle while the output skid entry is free; 30 of
// the stages are the per-axis divider, one quotient bit each. A two-entry
// output buffer decouples the stall. Reset (synchronous, active low) empties
// the pipeline and output buffer and sets every extent to 3.0 voxels.
// ----------------------------------------------------------------------------
// separable_sinc_quartic_weight_core
// Separable truncated-sinc weight: sinc(dx) * sinc(dy) * (1 - dz^2)^2.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_sinc_quartic_weight_core import sscw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic signed [COORD_W-1:0] i_centre_x,
    input  logic signed [COORD_W-1:0] i_centre_y,
    input  logic signed [COORD_W-1:0] i_centre_z,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [W_W-1:0]     o_weight,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_AW-1:0]         i_cfg_index,
    input  logic [EXT_W-1:0]          i_cfg_data
);

    localparam int NSTG  = 4 + AX_LAT;
    localparam int DLY   = AX_LAT - Z_LAT;
    localparam int ZP_W  = 2 * Q_BITS;
    localparam int PP_W  = 2 * MAG_W;

    logic             w_en;
    logic             r_vld [NSTG];

    logic [EXT_W-1:0] r_ext_x;
    logic [EXT_W-1:0] r_ext_y;
    logic [EXT_W-1:0] r_ext_z;

    logic signed [D_W-1:0] r1_dx;
    logic signed [D_W-1:0] r1_dy;
    logic signed [D_W-1:0] r1_dz;
    logic [D_W-1:0]        w_ax;
    logic [D_W-1:0]        w_ay;
    logic [D_W-1:0]        w_az;
    logic [U_W-1:0]        r2_ux;
    logic [U_W-1:0]        r2_uy;
    logic [FRAC_BITS-1:0]  r2_az;
    logic                  r2_ok;

    logic [ZP_W-1:0]  r_z1_p;
    logic             r_z1_ok;
    logic [MAG_W-1:0] r_z2_om;
    logic             r_z2_ok;
    logic [PP_W-1:0]  r_z3_p;
    logic             r_z3_ok;
    t_zside           r_z4;
    t_zside           r_zd [DLY];

    logic [MAG_W-1:0] w_mx;
    logic [MAG_W-1:0] w_my;
    logic             w_nx;
    logic             w_ny;

    logic [PP_W-1:0]  r_f1_p;
    logic [MAG_W-1:0] r_f1_fz;
    logic             r_f1_ok;
    logic             r_f1_neg;
    logic [PP_W-1:0]  r_f2_p;
    logic             r_f2_ok;
    logic             r_f2_neg;

    logic [MAG_W-1:0] w_mag;
    logic [MAG_W-1:0] w_rsum;
    logic [O_W-1:0]   w_o;
    logic [O_W-1:0]   w_oc;
    logic [W_W-1:0]   w_w;

    logic             r_out_vld;
    logic [W_W-1:0]   r_out_w;
    logic             r_skid_vld;
    logic [W_W-1:0]   r_skid_w;

    // whole pipeline moves while the skid entry is free
    assign w_en        = !r_skid_vld;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_x <= EXT_RESET;
            r_ext_y <= EXT_RESET;
            r_ext_z <= EXT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXT_X: r_ext_x <= i_cfg_data;
                CFG_EXT_Y: r_ext_y <= i_cfg_data;
                CFG_EXT_Z: r_ext_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSTG; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < NSTG; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // displacement
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= D_W'(i_pos_x) - D_W'(i_centre_x);
            r1_dy <= D_W'(i_pos_y) - D_W'(i_centre_y);
            r1_dz <= D_W'(i_pos_z) - D_W'(i_centre_z);
        end
    end

    // inclusive bounds -e <= d <= e are |d| <= e
    assign w_ax = r1_dx[D_W-1] ? D_W'(-r1_dx) : D_W'(r1_dx);
    assign w_ay = r1_dy[D_W-1] ? D_W'(-r1_dy) : D_W'(r1_dy);
    assign w_az = r1_dz[D_W-1] ? D_W'(-r1_dz) : D_W'(r1_dz);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ux <= w_ax[U_W-1:0];
            r2_uy <= w_ay[U_W-1:0];
            r2_az <= w_az[FRAC_BITS-1:0];
            r2_ok <= (w_ax <= D_W'(r_ext_x)) && (w_ay <= D_W'(r_ext_y))
                  && (w_az <= D_W'(r_ext_z)) && (w_az < (D_W'(1) << FRAC_BITS));
        end
    end

    sscw_axis u_axis_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_u   (r2_ux),
        .o_mag (w_mx),
        .o_neg (w_nx)
    );

    sscw_axis u_axis_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_u   (r2_uy),
        .o_mag (w_my),
        .o_neg (w_ny)
    );

    // quartic window (1 - z^2)^2
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z1_p     <= ZP_W'({r2_az, (Q_BITS - FRAC_BITS)'(0)})
                        * ZP_W'({r2_az, (Q_BITS - FRAC_BITS)'(0)});
            r_z1_ok    <= r2_ok;
            r_z2_om    <= ONE_Q - MAG_W'(r_z1_p[ZP_W-1:Q_BITS]);
            r_z2_ok    <= r_z1_ok;
            r_z3_p     <= PP_W'(r_z2_om) * PP_W'(r_z2_om);
            r_z3_ok    <= r_z2_ok;
            r_z4.fz    <= r_z3_p[Q_BITS+MAG_W-1:Q_BITS];
            r_z4.ok    <= r_z3_ok;
            r_zd[0]    <= r_z4;
            for (int i = 1; i < DLY; i++) begin
                r_zd[i] <= r_zd[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_p   <= PP_W'(w_mx) * PP_W'(w_my);
            r_f1_fz  <= r_zd[DLY-1].fz;
            r_f1_ok  <= r_zd[DLY-1].ok;
            r_f1_neg <= w_nx ^ w_ny;
            r_f2_p   <= PP_W'(r_f1_p[Q_BITS+MAG_W-1:Q_BITS]) * PP_W'(r_f1_fz);
            r_f2_ok  <= r_f1_ok;
            r_f2_neg <= r_f1_neg;
        end
    end

    // round half up on the magnitude, saturate, then apply sign; zero when out of range
    assign w_mag  = r_f2_p[Q_BITS+MAG_W-1:Q_BITS];
    assign w_rsum = w_mag + (MAG_W'(1) << (Q_BITS - OUT_FRAC - 1));
    assign w_o    = w_rsum[MAG_W-1:Q_BITS-OUT_FRAC];
    assign w_oc   = (w_o > O_W'(OUT_MAX)) ? O_W'(OUT_MAX) : w_o;
    assign w_w    = !r_f2_ok ? '0 : (r_f2_neg ? W_W'(0) - W_W'(w_oc) : W_W'(w_oc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || i_ready) begin
            r_out_vld <= r_vld[NSTG-1];
        end else if (r_vld[NSTG-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out_w <= r_skid_w;
            end
        end else if (!r_out_vld || i_ready) begin
            r_out_w <= w_w;
        end else begin
            r_skid_w <= w_w;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_weight = r_out_w;

endmodule

`default_nettype wire

[dv/separable_sinc_quartic_weight_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_sinc_quartic_weight_core_tb
// Drives position/centre pairs through the weight core under several extent
// settings and idle/stall mixes, and compares each weight against an
// in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module separable_sinc_quartic_weight_core_tb;
    import sscw_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 50;
    localparam longint unsigned Q_ONE = 64'd1 << 30;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam longint unsigned FULL_PI = 64'd3373259426;
    localparam longint unsigned EXT_MASK = 64'h7FFFFF;

    class weight_board;
        logic signed [W_W-1:0] pending_weights[$];
        longint unsigned ext_x = 196608, ext_y = 196608, ext_z = 196608;

        function void set_extent(logic [CFG_AW-1:0] idx, logic [EXT_W-1:0] val);
            case (idx)
                CFG_EXT_X: ext_x = val;
                CFG_EXT_Y: ext_y = val;
                CFG_EXT_Z: ext_z = val;
                default: ;
            endcase
        endfunction

        function longint unsigned sine_q30(longint unsigned k);
            longint unsigned x, x2, term, sum;
            x = (k * HALF_PI) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 3; n <= 13; n += 2) begin
                term = ((term * x2) >> 30) / longint'(n * (n - 1));
                if ((n >> 1) & 1) sum = (sum >= term) ? sum - term : 0;
                else sum = sum + term;
            end
            return (sum > Q_ONE) ? Q_ONE : sum;
        endfunction

        function longint unsigned sinc_q30(longint unsigned u, output bit neg);
            longint unsigned fmask, quarter, p, k, r, s, t0, t1, den, v;
            fmask = (64'd1 << FRAC_BITS) - 1;
            quarter = 64'd1 << (SINE_TABLE_BITS + FRAC_BITS);
            neg = 0;
            if (u == 0) return Q_ONE;
            neg = ((u >> FRAC_BITS) & 1) != 0;
            p = (u & fmask) << (SINE_TABLE_BITS + 1);
            if (p > quarter) p = 2 * quarter - p;
            k = p >> FRAC_BITS;
            r = p & fmask;
            t0 = sine_q30(k);
            if (k >= (64'd1 << SINE_TABLE_BITS)) begin
                s = t0;
            end else begin
                t1 = sine_q30(k + 1);
                s = t0 + (((t1 > t0) ? t1 - t0 : 0) * r >> FRAC_BITS);
            end
            den = (FULL_PI * u) >> FRAC_BITS;
            if (den == 0) return Q_ONE;
            v = (s << 30) / den;
            return (v > Q_ONE) ? Q_ONE : v;
        endfunction

        function bit in_extent(longint d, longint unsigned ext);
            longint e;
            e = longint'(ext & EXT_MASK);
            return d >= -e && d <= e;
        endfunction

        function logic signed [W_W-1:0] predict(logic signed [31:0] px, py, pz,
                                                logic signed [31:0] cx, cy, cz);
            longint dx, dy, dz;
            longint unsigned az, z30, z2, om, fz, mx, my, mag, o;
            bit nx, ny;
            dx = longint'(px) - longint'(cx);
            dy = longint'(py) - longint'(cy);
            dz = longint'(pz) - longint'(cz);
            if (!in_extent(dx, ext_x) || !in_extent(dy, ext_y) || !in_extent(dz, ext_z))
                return '0;
            az = (dz < 0) ? -dz : dz;
            if (az >= (64'd1 << FRAC_BITS)) return '0;
            z30 = az << (30 - FRAC_BITS);
            z2 = (z30 * z30) >> 30;
            om = Q_ONE - z2;
            fz = (om * om) >> 30;
            mx = sinc_q30((dx < 0) ? -dx : dx, nx);
            my = sinc_q30((dy < 0) ? -dy : dy, ny);
            mag = (mx * my) >> 30;
            mag = (mag * fz) >> 30;
            o = (mag + (64'd1 << 13)) >> 14;
            if (o > OUT_MAX) o = OUT_MAX;
            return (nx != ny) ? -W_W'(o) : W_W'(o);
        endfunction

        function void note_pair(logic signed [31:0] px, py, pz, cx, cy, cz);
            pending_weights.push_back(predict(px, py, pz, cx, cy, cz));
        endfunction

        // returns 0 on mismatch or when nothing was waiting
        function bit check_weight(logic signed [W_W-1:0] got,
                                  output logic signed [W_W-1:0] want, output bit none);
            none = pending_weights.size() == 0;
            want = '0;
            if (none) return 0;
            want = pending_weights.pop_front();
            return got === want;
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [COORD_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [COORD_W-1:0] i_centre_x, i_centre_y, i_centre_z;
    logic signed [W_W-1:0] o_weight;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_index;
    logic [EXT_W-1:0] i_cfg_data;

    weight_board sb = new();
    int errors = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    separable_sinc_quartic_weight_core u_top (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        logic signed [W_W-1:0] want;
        bit none;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_pair(i_pos_x, i_pos_y, i_pos_z, i_centre_x, i_centre_y, i_centre_z);
            if (o_valid && i_ready) begin
                if (!sb.check_weight(o_weight, want, none)) begin
                    if (none) report($sformatf("unexpected weight %0d", o_weight));
                    else report($sformatf("weight got %0d want %0d", o_weight, want));
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("separable_sinc_quartic_weight_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_extent(logic [CFG_AW-1:0] idx, logic [EXT_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_extent(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_pair(int idle_pct, logic signed [31:0] px, py, pz, cx, cy, cz);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_pos_x <= px;  i_pos_y <= py;  i_pos_z <= pz;
        i_centre_x <= cx; i_centre_y <= cy; i_centre_z <= cz;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // sender pauses until every pending weight has come back
    task automatic drain();
        i_valid <= 0;
        while (sb.pending_weights.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_disp(longint unsigned ext, bit z_axis);
        longint lim, d;
        lim = (ext == 0) ? 1 : longint'(ext);
        if (z_axis && lim > 65536) lim = 65536;
        if (!z_axis && lim > 262144 && $urandom_range(3) != 0) lim = 262144;
        case ($urandom_range(9))
            0: d = 0;
            1: d = longint'(ext);
            2: d = longint'(ext) + 1;
            3: d = longint'($urandom_range(4)) * 65536;
            4: d = 32768;
            default: d = longint'($urandom_range(0, int'(lim)));
        endcase
        if ($urandom_range(1)) d = -d;
        return 32'(d);
    endfunction

    task automatic random_pairs(int count, int idle_pct);
        logic signed [31:0] cx, cy, cz, px, py, pz;
        repeat (count) begin
            cx = $urandom; cy = $urandom; cz = $urandom;
            if ($urandom_range(9) == 0) begin
                px = $urandom; py = $urandom; pz = $urandom;
            end else begin
                px = cx + pick_disp(sb.ext_x, 0);
                py = cy + pick_disp(sb.ext_y, 0);
                pz = cz + pick_disp(sb.ext_z, 1);
            end
            send_pair(idle_pct, px, py, pz, cx, cy, cz);
        end
    endtask

    initial begin
        logic [EXT_W-1:0] ex, ey, ez;
        int idle_mix[4] = '{0, 48, 0, 34};
        int stall_mix[4] = '{0, 0, 48, 34};
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_EXT_X;
        i_cfg_data = '0;
        {i_pos_x, i_pos_y, i_pos_z, i_centre_x, i_centre_y, i_centre_z} = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed corners at reset extents (3.0 voxels)
        send_pair(0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 32'h10000, 0, 0, 0, 0, 0);         // sinc zero crossing
        send_pair(0, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0);
        send_pair(0, -32'sh18000, 32'h8000, 0, 0, 0, 0); // odd lobe, negative
        send_pair(0, 32'h18000, 32'h28000, -32'sh4000, 0, 0, 0);
        send_pair(0, 0, 0, 32'h10000, 0, 0, 0);          // dz at one voxel
        send_pair(0, 0, 0, 32'hFFFF, 0, 0, 0);
        send_pair(0, 0, 0, -32'shFFFF, 0, 0, 0);
        send_pair(0, 32'h30000, -32'sh30000, 0, 0, 0, 0);     // inclusive bound
        send_pair(0, 32'h30001, 0, 0, 0, 0, 0);             // just outside
        send_pair(0, 0, -32'sh30001, 0, 0, 0, 0);
        send_pair(0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0);
        send_pair(0, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000);
        send_pair(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFE);
        send_pair(0, 32'hFFFFFFFF, 32'h1, 0, 0, 0, 0);
        send_pair(0, 32'h2FFFF, 32'h1, 0, 0, 0, 0);
        drain();

        for (int s = 0; s < 4; s++) begin
            case (s)
                0: begin ex = 23'h7FFFFF; ey = 23'h7FFFFF; ez = 23'h7FFFFF; end
                1: begin ex = '0; ey = '0; ez = '0; end
                2: begin ex = 23'h30000; ey = 23'h30000; ez = 23'h30000; end
                default: begin
                    ex = EXT_W'($urandom_range(0, 23'h7FFFF));
                    ey = EXT_W'($urandom_range(0, 23'h7FFFF));
                    ez = EXT_W'($urandom_range(0, 23'h20000));
                end
            endcase
            write_extent(CFG_EXT_X, ex);
            write_extent(CFG_EXT_Y, ey);
            write_extent(CFG_EXT_Z, ez);
            write_extent(CFG_UNUSED, EXT_W'($urandom));   // no register behind this index
            for (int m = 0; m < 4; m++) begin
                stall_pct = stall_mix[m];
                random_pairs(65, idle_mix[m]);
            end
            drain();
        end

        stall_pct = 0;
        drain();
        if (errors == 0) begin
            $display("separable_sinc_quartic_weight_core verification clean");
        end else begin
            $display("separable_sinc_quartic_weight_core verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/sscw_pkg.sv
rtl/core/sscw_sine_rom.sv
rtl/core/sscw_div.sv
rtl/core/sscw_axis.sv
rtl/core/separable_sinc_quartic_weight_core.sv
dv/separable_sinc_quartic_weight_core_tb.sv
